// ===== rtl/vrp_pkg.sv =====
// Shared constants, register codes and the sine table generator for the vertex transform.
package vrp_pkg;

    localparam int ANGLE_BITS_DEF  = 10;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int TRIG_W          = 16;
    localparam int SCREEN_W        = 16;
    localparam int CENTER_W        = 12;
    localparam int SCALE_W         = 16;
    localparam int REG_IDX_W       = 3;
    localparam int DIST_Q8         = 12800;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ANGLE_X  = 3'd0,
        REG_ANGLE_Y  = 3'd1,
        REG_ANGLE_Z  = 3'd2,
        REG_SCALE    = 3'd3,
        REG_CENTER_X = 3'd4,
        REG_CENTER_Y = 3'd5
    } cfg_reg_t;

    localparam int unsigned TAYLOR_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

    // Quarter-wave sine entry k in Q1.14, evaluated only at elaboration.
    function automatic logic signed [TRIG_W-1:0] qsin(input int unsigned k,
                                                      input int unsigned ab);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        int unsigned sh;
        sh  = ab - 2;
        th  = (64'(k) * HALF_PI_Q30 + (64'd1 << (sh - 1))) >> sh;
        th2 = (th * th) >> 30;
        t   = th;
        pos = th;
        neg = '0;
        for (int n = 1; n <= 8; n++) begin
            t = ((t * th2) >> 30) / 64'(TAYLOR_DIV[n]);
            if (n[0]) begin
                neg = neg + t;
            end else begin
                pos = pos + t;
            end
        end
        r = (((pos - neg) << 14) + (64'd1 << 29)) >> 30;
        return r[TRIG_W-1:0];
    endfunction

endpackage

// ===== rtl/vertex_rotate_project_core.sv =====
// Top level: configuration registers, input stage, three rotations and the projection.
//
// Each vertex is rotated about X, Y and Z and then projected for a camera at distance 50.
// The block takes one vertex per clock when not stalled and returns one result per vertex, in
// order, through one input register, two stages per rotation axis, two stages of scale
// products, one restoring divider stage per quotient bit (COORD_WIDTH + 14 of them), and the
// output register. The divider sets the depth. The whole pipeline holds while a result waits
// on m_tready, and moves again as soon as it is taken. Angle, scale and center registers are
// meant to be written between meshes.
module vertex_rotate_project_core import vrp_pkg::*; #(
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [((ANGLE_BITS > SCALE_W) ? ANGLE_BITS : SCALE_W)-1:0] cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // in_x, in_y, in_z from bit 0 up, zero padded to whole bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // rot_x, rot_y, rot_z, screen_x, screen_y from bit 0 up, zero padded to whole bytes
    output logic [((3*COORD_WIDTH+2*SCREEN_W+7)/8)*8-1:0] m_tdata,
    // behind_camera
    output logic [0:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_W  = ((3*CW + 2*SCREEN_W + 7) / 8) * 8;

    logic [ANGLE_BITS-1:0]       angle_x_reg, angle_y_reg, angle_z_reg;
    logic [SCALE_W-1:0]          scale_reg;
    logic signed [CENTER_W-1:0]  center_x_reg, center_y_reg;

    logic                        adv;
    logic                        v0_reg;
    logic signed [CW-1:0]        x0_reg, y0_reg, z0_reg;
    logic                        last0_reg;

    logic signed [TRIG_W-1:0]    sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

    logic                        v1, v2, v3;
    logic signed [CW-1:0]        x1, y1, z1, x2, y2, z2, x3, y3, z3;
    logic                        last1, last2, last3;

    logic                        out_valid;
    logic signed [CW-1:0]        rot_x_o, rot_y_o, rot_z_o;
    logic signed [SCREEN_W-1:0]  screen_x_o, screen_y_o;
    logic                        behind_o, last_o;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_x_reg  <= '0;
            angle_y_reg  <= '0;
            angle_z_reg  <= '0;
            scale_reg    <= SCALE_W'(256);
            center_x_reg <= '0;
            center_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ANGLE_X:  angle_x_reg  <= cfg_data[ANGLE_BITS-1:0];
                REG_ANGLE_Y:  angle_y_reg  <= cfg_data[ANGLE_BITS-1:0];
                REG_ANGLE_Z:  angle_z_reg  <= cfg_data[ANGLE_BITS-1:0];
                REG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                REG_CENTER_X: center_x_reg <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // Every stage moves together; the output register is the last stage.
    assign adv      = !out_valid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg    <= s_tdata[CW-1:0];
            y0_reg    <= s_tdata[2*CW-1:CW];
            z0_reg    <= s_tdata[3*CW-1:2*CW];
            last0_reg <= s_tlast;
        end
    end

    vrp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_x (
        .aclk (aclk), .angle (angle_x_reg), .sin_reg (sin_x), .cos_reg (cos_x)
    );
    vrp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_y (
        .aclk (aclk), .angle (angle_y_reg), .sin_reg (sin_y), .cos_reg (cos_y)
    );
    vrp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_z (
        .aclk (aclk), .angle (angle_z_reg), .sin_reg (sin_z), .cos_reg (cos_z)
    );

    vrp_rot #(.CW(CW), .SIDE_W(CW+1)) u_rot_x (
        .aclk (aclk), .aresetn (aresetn), .en (adv), .in_valid (v0_reg),
        .a (y0_reg), .b (z0_reg), .sin_v (sin_x), .cos_v (cos_x),
        .side_in ({x0_reg, last0_reg}),
        .out_valid (v1), .na (y1), .nb (z1), .side_out ({x1, last1})
    );

    vrp_rot #(.CW(CW), .SIDE_W(CW+1)) u_rot_y (
        .aclk (aclk), .aresetn (aresetn), .en (adv), .in_valid (v1),
        .a (z1), .b (x1), .sin_v (sin_y), .cos_v (cos_y),
        .side_in ({y1, last1}),
        .out_valid (v2), .na (z2), .nb (x2), .side_out ({y2, last2})
    );

    vrp_rot #(.CW(CW), .SIDE_W(CW+1)) u_rot_z (
        .aclk (aclk), .aresetn (aresetn), .en (adv), .in_valid (v2),
        .a (x2), .b (y2), .sin_v (sin_z), .cos_v (cos_z),
        .side_in ({z2, last2}),
        .out_valid (v3), .na (x3), .nb (y3), .side_out ({z3, last3})
    );

    vrp_proj #(.CW(CW)) u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v3),
        .rx        (x3),
        .ry        (y3),
        .rz        (z3),
        .last_in   (last3),
        .scale     (scale_reg),
        .cx        (center_x_reg),
        .cy        (center_y_reg),
        .out_valid (out_valid),
        .rot_x     (rot_x_o),
        .rot_y     (rot_y_o),
        .rot_z     (rot_z_o),
        .screen_x  (screen_x_o),
        .screen_y  (screen_y_o),
        .behind    (behind_o),
        .last_out  (last_o)
    );

    assign m_tvalid   = out_valid;
    assign m_tdata    = OUT_W'({screen_y_o, screen_x_o, rot_z_o, rot_y_o, rot_x_o});
    assign m_tuser[0] = behind_o;
    assign m_tlast    = last_o;

`ifndef SYNTH
    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_behind_screen_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && behind_o) |->
            (screen_x_o == 16'sh7fff || screen_x_o == 16'sh8000 ||
             screen_x_o == SCREEN_W'(center_x_reg)))
        else $error("behind-camera screen x is not saturated or centered");

    a_front_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !behind_o) |-> (rot_z_o < DIST_Q8))
        else $error("in-front result with depth at or beyond camera");
`endif

endmodule

// ===== rtl/vrp_trig.sv =====
// Sine and cosine lookup from a quarter-wave table, registered.
module vrp_trig import vrp_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic [ANGLE_BITS-1:0]    angle,
    output logic signed [TRIG_W-1:0] sin_reg,
    output logic signed [TRIG_W-1:0] cos_reg
);

    localparam int QW = ANGLE_BITS - 2;
    localparam int Q  = 1 << QW;
    localparam logic signed [TRIG_W-1:0] PEAK = qsin(Q, ANGLE_BITS);

    logic signed [TRIG_W-1:0] rom [Q];
    logic [ANGLE_BITS-1:0]    ang [2];
    logic signed [TRIG_W-1:0] val [2];

    for (genvar k = 0; k < Q; k++) begin : g_rom
        localparam logic signed [TRIG_W-1:0] V = qsin(k, ANGLE_BITS);
        assign rom[k] = V;
    end

    assign ang[0] = angle;
    assign ang[1] = angle + ANGLE_BITS'(Q);

    always_comb begin
        logic [1:0]               quad;
        logic [QW-1:0]            i;
        logic [QW:0]              idx;
        logic signed [TRIG_W-1:0] mag;
        for (int j = 0; j < 2; j++) begin
            quad = ang[j][ANGLE_BITS-1:ANGLE_BITS-2];
            i    = ang[j][QW-1:0];
            idx  = quad[0] ? ((QW+1)'(Q) - {1'b0, i}) : {1'b0, i};
            // The table stops just short of the peak; the quarter point reads it directly.
            mag  = idx[QW] ? PEAK : rom[idx[QW-1:0]];
            val[j] = quad[1] ? -mag : mag;
        end
    end

    always_ff @(posedge aclk) begin
        sin_reg <= val[0];
        cos_reg <= val[1];
    end

endmodule

// ===== rtl/vrp_rot.sv =====
// One plane rotation: products in the first stage, rounded and saturated sums in the second.
module vrp_rot import vrp_pkg::*; #(
    parameter int CW     = COORD_WIDTH_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [CW-1:0]     a,
    input  logic signed [CW-1:0]     b,
    input  logic signed [TRIG_W-1:0] sin_v,
    input  logic signed [TRIG_W-1:0] cos_v,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     out_valid,
    output logic signed [CW-1:0]     na,
    output logic signed [CW-1:0]     nb,
    output logic [SIDE_W-1:0]        side_out
);

    localparam int PW = CW + TRIG_W;
    localparam int SW = PW + 1;

    logic                 v1_reg;
    logic                 v2_reg;
    logic signed [PW-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [PW-1:0] ac_next, bs_next, as_next, bc_next;
    logic [SIDE_W-1:0]    side1_reg, side2_reg;
    logic signed [CW-1:0] na_reg, nb_reg, na_next, nb_next;

    function automatic logic signed [CW-1:0] rnd_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] r;
        r = (s + SW'(8192)) >>> 14;
        if (r[SW-1:CW-1] == {(SW-CW+1){r[SW-1]}}) begin
            return r[CW-1:0];
        end
        return r[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    always_comb begin
        ac_next = a * cos_v;
        bs_next = b * sin_v;
        as_next = a * sin_v;
        bc_next = b * cos_v;
        na_next = rnd_sat(SW'(ac_reg) - SW'(bs_reg));
        nb_next = rnd_sat(SW'(as_reg) + SW'(bc_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ac_reg    <= ac_next;
            bs_reg    <= bs_next;
            as_reg    <= as_next;
            bc_reg    <= bc_next;
            side1_reg <= side_in;
            na_reg    <= na_next;
            nb_reg    <= nb_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign na        = na_reg;
    assign nb        = nb_reg;
    assign side_out  = side2_reg;

endmodule

// ===== rtl/vrp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, divisor carried with the item.
module vrp_div import vrp_pkg::*; #(
    parameter int NQ     = COORD_WIDTH_DEF + 14,
    parameter int DU     = COORD_WIDTH_DEF,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NQ-1:0]     dividend,
    input  logic [DU-1:0]     divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [NQ-1:0]     quotient,
    output logic [SIDE_W-1:0] side_out
);

    logic              v_reg    [NQ];
    logic [DU-1:0]     rem_reg  [NQ];
    logic [NQ-1:0]     a_reg    [NQ];
    logic [DU-1:0]     d_reg    [NQ];
    logic [SIDE_W-1:0] side_reg [NQ];

    for (genvar s = 0; s < NQ; s++) begin : g_stage
        logic              v_in;
        logic [DU-1:0]     rem_in;
        logic [NQ-1:0]     a_in;
        logic [DU-1:0]     d_in;
        logic [SIDE_W-1:0] side_stage;
        logic [DU:0]       t;
        logic              ge;
        logic [DU-1:0]     rem_next;
        logic [NQ-1:0]     a_next;

        if (s == 0) begin : g_first
            assign v_in       = in_valid;
            assign rem_in     = '0;
            assign a_in       = dividend;
            assign d_in       = divisor;
            assign side_stage = side_in;
        end else begin : g_next
            assign v_in       = v_reg[s-1];
            assign rem_in     = rem_reg[s-1];
            assign a_in       = a_reg[s-1];
            assign d_in       = d_reg[s-1];
            assign side_stage = side_reg[s-1];
        end

        // Dividend bits shift out at the top while quotient bits shift in at the bottom.
        always_comb begin
            t        = {rem_in, a_in[NQ-1]};
            ge       = t >= {1'b0, d_in};
            rem_next = ge ? DU'(t - {1'b0, d_in}) : t[DU-1:0];
            a_next   = {a_in[NQ-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                a_reg[s]    <= a_next;
                d_reg[s]    <= d_in;
                side_reg[s] <= side_stage;
            end
        end
    end

    assign out_valid = v_reg[NQ-1];
    assign quotient  = a_reg[NQ-1];
    assign side_out  = side_reg[NQ-1];

endmodule

// ===== rtl/vrp_proj.sv =====
// Perspective projection: scale products, camera distance, two dividers and the final offset.
module vrp_proj import vrp_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [CW-1:0]       rx,
    input  logic signed [CW-1:0]       ry,
    input  logic signed [CW-1:0]       rz,
    input  logic                       last_in,
    input  logic [SCALE_W-1:0]         scale,
    input  logic signed [CENTER_W-1:0] cx,
    input  logic signed [CENTER_W-1:0] cy,
    output logic                       out_valid,
    output logic signed [CW-1:0]       rot_x,
    output logic signed [CW-1:0]       rot_y,
    output logic signed [CW-1:0]       rot_z,
    output logic signed [SCREEN_W-1:0] screen_x,
    output logic signed [SCREEN_W-1:0] screen_y,
    output logic                       behind,
    output logic                       last_out
);

    localparam int DU  = (CW > 15) ? CW : 15;
    localparam int DW  = DU + 1;
    localparam int NQ  = CW + 14;
    localparam int MW  = CW + 22;
    localparam int PRW = CW + SCALE_W;
    localparam int XS_W = 3 * CW + 4;

    logic                 p1_v_reg, p2_v_reg;
    logic signed [DW-1:0] den_reg, den_next;
    logic [PRW-1:0]       px_reg, py_reg, px_next, py_next;
    logic [CW-1:0]        magx, magy;
    logic                 negx1_reg, nzx1_reg, negy1_reg, nzy1_reg;
    logic signed [CW-1:0] rx1_reg, ry1_reg, rz1_reg, rx2_reg, ry2_reg, rz2_reg;
    logic                 last1_reg, last2_reg;
    logic                 negx2_reg, nzx2_reg, negy2_reg, nzy2_reg;
    logic [NQ-1:0]        ax_reg, ay_reg, ax_next, ay_next;
    logic [DU-1:0]        du_reg;
    logic                 behind2_reg, behind_next;
    logic [MW-1:0]        mx, my;

    logic [XS_W-1:0]      xs_in, xs_out;
    logic [1:0]           ys_in, ys_out;
    logic                 dx_valid, dy_valid;
    logic [NQ-1:0]        qx, qy;
    logic signed [CW-1:0] rx3, ry3, rz3;
    logic                 last3, behind3, negx3, nzx3, negy3, nzy3;

    logic                       o_valid_reg;
    logic signed [CW-1:0]       o_rx_reg, o_ry_reg, o_rz_reg;
    logic signed [SCREEN_W-1:0] o_sx_reg, o_sy_reg, o_sx_next, o_sy_next;
    logic                       o_behind_reg, o_last_reg;

    function automatic logic signed [SCREEN_W-1:0] finish(
        input logic [NQ-1:0]              q,
        input logic                       neg,
        input logic                       nz,
        input logic                       bh,
        input logic signed [CENTER_W-1:0] ctr
    );
        logic signed [NQ+1:0] qs;
        logic signed [NQ+1:0] sum;
        qs  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        sum = qs + (NQ+2)'(ctr);
        // Behind the camera the quotient is unused; numerator sign and zero test decide.
        if (bh) begin
            if (!nz) begin
                return SCREEN_W'(ctr);
            end
            return neg ? {1'b1, {(SCREEN_W-1){1'b0}}} : {1'b0, {(SCREEN_W-1){1'b1}}};
        end
        if (sum[NQ+1:SCREEN_W-1] == {(NQ-SCREEN_W+3){sum[NQ+1]}}) begin
            return sum[SCREEN_W-1:0];
        end
        return sum[NQ+1] ? {1'b1, {(SCREEN_W-1){1'b0}}} : {1'b0, {(SCREEN_W-1){1'b1}}};
    endfunction

    always_comb begin
        den_next    = DW'(DIST_Q8) - DW'(rz);
        magx        = rx[CW-1] ? CW'(-rx) : rx;
        magy        = ry[CW-1] ? CW'(-ry) : ry;
        px_next     = magx * scale;
        py_next     = magy * scale;
        // Times 50 as 32 + 16 + 2, then the Q8.8 scale is dropped.
        mx          = (MW'(px_reg) << 5) + (MW'(px_reg) << 4) + (MW'(px_reg) << 1);
        my          = (MW'(py_reg) << 5) + (MW'(py_reg) << 4) + (MW'(py_reg) << 1);
        ax_next     = mx[MW-1:8];
        ay_next     = my[MW-1:8];
        behind_next = den_reg[DW-1] || (den_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end else if (en) begin
            p1_v_reg <= in_valid;
            p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg     <= den_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            negx1_reg   <= rx[CW-1];
            negy1_reg   <= ry[CW-1];
            nzx1_reg    <= (rx != '0) && (scale != '0);
            nzy1_reg    <= (ry != '0) && (scale != '0);
            rx1_reg     <= rx;
            ry1_reg     <= ry;
            rz1_reg     <= rz;
            last1_reg   <= last_in;
            ax_reg      <= ax_next;
            ay_reg      <= ay_next;
            du_reg      <= den_reg[DU-1:0];
            behind2_reg <= behind_next;
            negx2_reg   <= negx1_reg;
            negy2_reg   <= negy1_reg;
            nzx2_reg    <= nzx1_reg;
            nzy2_reg    <= nzy1_reg;
            rx2_reg     <= rx1_reg;
            ry2_reg     <= ry1_reg;
            rz2_reg     <= rz1_reg;
            last2_reg   <= last1_reg;
        end
    end

    assign xs_in = {rx2_reg, ry2_reg, rz2_reg, last2_reg, behind2_reg, negx2_reg, nzx2_reg};
    assign ys_in = {negy2_reg, nzy2_reg};

    vrp_div #(.NQ(NQ), .DU(DU), .SIDE_W(XS_W)) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p2_v_reg),
        .dividend  (ax_reg),
        .divisor   (du_reg),
        .side_in   (xs_in),
        .out_valid (dx_valid),
        .quotient  (qx),
        .side_out  (xs_out)
    );

    vrp_div #(.NQ(NQ), .DU(DU), .SIDE_W(2)) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p2_v_reg),
        .dividend  (ay_reg),
        .divisor   (du_reg),
        .side_in   (ys_in),
        .out_valid (dy_valid),
        .quotient  (qy),
        .side_out  (ys_out)
    );

    assign {rx3, ry3, rz3, last3, behind3, negx3, nzx3} = xs_out;
    assign {negy3, nzy3} = ys_out;

    always_comb begin
        o_sx_next = finish(qx, negx3, nzx3, behind3, cx);
        o_sy_next = finish(qy, negy3, nzy3, behind3, cy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= dx_valid && dy_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_rx_reg     <= rx3;
            o_ry_reg     <= ry3;
            o_rz_reg     <= rz3;
            o_sx_reg     <= o_sx_next;
            o_sy_reg     <= o_sy_next;
            o_behind_reg <= behind3;
            o_last_reg   <= last3;
        end
    end

    assign out_valid = o_valid_reg;
    assign rot_x     = o_rx_reg;
    assign rot_y     = o_ry_reg;
    assign rot_z     = o_rz_reg;
    assign screen_x  = o_sx_reg;
    assign screen_y  = o_sy_reg;
    assign behind    = o_behind_reg;
    assign last_out  = o_last_reg;

endmodule
